// File: sv/wfc_pkg.sv
// Package for the word frequency counter: payload structs, report kinds,
// queue depth and the byte classification functions. No dependencies.
`default_nettype none
package wfc_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_WORD_CHARS_DEF = 31;
  localparam int TABLE_ENTRIES_DEF  = 16;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Report kinds.
  localparam logic [1:0] KIND_WORD  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_TOTAL = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  report_kind;
    logic [3:0]  entry_index;
    logic [15:0] count_value;
    logic        was_new;
    logic        truncated;
    logic        table_full;
    logic        last_result;
  } out_req_t;

  // One classified byte as passed from front to back.
  typedef struct packed {
    logic [7:0] up_byte;
    logic       sep;
    logic       eot;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE, B_LEN_RD, B_LEN_CHK, B_CHR_RD, B_CHR_CHK, B_MISS, B_CP_RD,
    B_CP_WR, B_NEW, B_HIT, B_REP_RD, B_REP_OUT, B_TOTAL
  } back_state_t;

  // True for bytes that split words.
  function automatic logic is_sep(input logic [7:0] b);
    logic r;
    case (b)
      8'h20, 8'h2C, 8'h2E, 8'h2D, 8'h2B, 8'h2A, 8'h2F, 8'h23, 8'h26,
      8'h3D, 8'h3B, 8'h3A, 8'h5F, 8'h22, 8'h27, 8'h3F, 8'h21, 8'h28,
      8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h0A, 8'h00: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // ASCII upper-casing of a..z; other bytes pass unchanged.
  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) r = b - 8'h20;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/wfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/wfc_front.sv
// Front end: accepts text bytes, classifies and upper-cases them, and holds
// one command for the queue. Depends on wfc_pkg.
`default_nettype none
module wfc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire wfc_pkg::in_req_t in_data,
  output logic                 cmd_valid,
  output wfc_pkg::cmd_t        cmd,
  input  wire logic            cmd_ready
);

  logic          fv_r, fv_nxt;
  wfc_pkg::cmd_t cmd_r, cmd_nxt;

  assign in_ready  = !fv_r || cmd_ready;
  assign cmd_valid = fv_r;
  assign cmd       = cmd_r;

  // Load a new classified request whenever the holding register frees up.
  always_comb begin
    fv_nxt  = fv_r;
    cmd_nxt = cmd_r;
    if (fv_r && cmd_ready) fv_nxt = 1'b0;
    if (in_valid && in_ready) begin
      fv_nxt          = 1'b1;
      cmd_nxt.up_byte = wfc_pkg::to_upper(in_data.text_byte);
      cmd_nxt.sep     = wfc_pkg::is_sep(in_data.text_byte);
      cmd_nxt.eot     = in_data.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fv_r <= 1'b0;
    else        fv_r <= fv_nxt;
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

// File: sv/wfc_fifo.sv
// Short command queue between front and back ends.
// Depends on wfc_pkg for the command type and depth.
`default_nettype none
module wfc_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire wfc_pkg::cmd_t push_cmd,
  output logic               push_ready,
  input  wire logic          pop,
  output logic               pop_valid,
  output wfc_pkg::cmd_t      pop_cmd
);

  localparam int AW = $clog2(wfc_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(wfc_pkg::QUEUE_DEPTH + 1);

  wfc_pkg::cmd_t slot_r [wfc_pkg::QUEUE_DEPTH];
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = count_r != CW'(wfc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = slot_r[head_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = (tail_r == AW'(wfc_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_r + AW'(1);
    end
    if (do_pop) begin
      head_nxt = (head_r == AW'(wfc_pkg::QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
    end
    if (do_push && !do_pop)      count_nxt = count_r + CW'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[tail_r] <= push_cmd;
  end

endmodule
`default_nettype wire

// File: sv/wfc_back.sv
// Back end: builds words, searches and updates the word table, and drives
// the result register. Depends on wfc_pkg and wfc_ram.
`default_nettype none
module wfc_back #(
  parameter int MAX_WORD_CHARS = wfc_pkg::MAX_WORD_CHARS_DEF,
  parameter int TABLE_ENTRIES  = wfc_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire wfc_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output wfc_pkg::out_req_t  out_data
);

  localparam int LW  = $clog2(MAX_WORD_CHARS + 1);
  localparam int WAW = $clog2(MAX_WORD_CHARS);
  localparam int UW  = $clog2(TABLE_ENTRIES + 1);
  localparam int EAW = $clog2(TABLE_ENTRIES);
  localparam int SD  = TABLE_ENTRIES * MAX_WORD_CHARS;
  localparam int SAW = $clog2(SD);
  localparam int BW  = $clog2(SD + 1);
  localparam int EW  = LW + 16;

  wfc_pkg::back_state_t state_r, state_nxt;

  logic          inside_r, inside_nxt, ovl_r, ovl_nxt, halted_r, halted_nxt;
  logic          eot_r, eot_nxt;
  logic [LW-1:0] len_r, len_nxt, i_r, i_nxt;
  logic [UW-1:0] used_r, used_nxt, e_r, e_nxt;
  logic [BW-1:0] base_r, base_nxt;
  logic [15:0]   total_r, total_nxt, cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  wfc_pkg::out_req_t od_r, od_nxt;

  // RAM controls.
  logic           wb_we, wb_re, st_we, st_re, en_we, en_re;
  logic [WAW-1:0] wb_waddr, wb_raddr;
  logic [7:0]     wb_wdata, wb_rdata, st_rdata;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [EAW-1:0] en_waddr, en_raddr;
  logic [EW-1:0]  en_wdata, en_rdata;

  logic           out_free, do_finish, last_i, full;
  logic [15:0]    cnt_inc;
  logic [UW-1:0]  e_dec;

  assign out_free  = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign cmd_pop   = (state_r == wfc_pkg::B_IDLE) && cmd_valid;
  assign do_finish = !halted_r && (inside_r ? (cmd.sep || cmd.eot) : (!cmd.sep && cmd.eot));
  assign last_i    = i_r == LW'(len_r - LW'(1));
  assign full      = used_r == UW'(TABLE_ENTRIES);
  assign cnt_inc   = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;
  assign e_dec     = e_r - UW'(1);

  wfc_ram #(.WIDTH(8), .DEPTH(MAX_WORD_CHARS)) u_word_ram (
    .clk(clk), .we(wb_we), .waddr(wb_waddr), .wdata(wb_wdata),
    .re(wb_re), .raddr(wb_raddr), .rdata(wb_rdata)
  );

  wfc_ram #(.WIDTH(8), .DEPTH(SD)) u_chars_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(wb_rdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  wfc_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
    .re(en_re), .raddr(en_raddr), .rdata(en_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wfc_pkg::B_IDLE: begin
        if (cmd_valid) begin
          if (do_finish)    state_nxt = wfc_pkg::B_LEN_RD;
          else if (cmd.eot) state_nxt = wfc_pkg::B_REP_RD;
        end
      end
      wfc_pkg::B_LEN_RD:  state_nxt = (e_r == used_r) ? wfc_pkg::B_MISS : wfc_pkg::B_LEN_CHK;
      wfc_pkg::B_LEN_CHK: begin
        state_nxt = (en_rdata[16 +: LW] == len_r) ? wfc_pkg::B_CHR_RD : wfc_pkg::B_LEN_RD;
      end
      wfc_pkg::B_CHR_RD:  state_nxt = wfc_pkg::B_CHR_CHK;
      wfc_pkg::B_CHR_CHK: begin
        if (st_rdata != wb_rdata) state_nxt = wfc_pkg::B_LEN_RD;
        else if (last_i)          state_nxt = wfc_pkg::B_HIT;
        else                      state_nxt = wfc_pkg::B_CHR_RD;
      end
      wfc_pkg::B_MISS: begin
        if (!full)        state_nxt = wfc_pkg::B_CP_RD;
        else if (out_free) state_nxt = eot_r ? wfc_pkg::B_REP_RD : wfc_pkg::B_IDLE;
      end
      wfc_pkg::B_CP_RD: state_nxt = wfc_pkg::B_CP_WR;
      wfc_pkg::B_CP_WR: state_nxt = last_i ? wfc_pkg::B_NEW : wfc_pkg::B_CP_RD;
      wfc_pkg::B_NEW, wfc_pkg::B_HIT: begin
        if (out_free) state_nxt = eot_r ? wfc_pkg::B_REP_RD : wfc_pkg::B_IDLE;
      end
      wfc_pkg::B_REP_RD:  state_nxt = (e_r == '0) ? wfc_pkg::B_TOTAL : wfc_pkg::B_REP_OUT;
      wfc_pkg::B_REP_OUT: if (out_free) state_nxt = wfc_pkg::B_REP_RD;
      wfc_pkg::B_TOTAL:   if (out_free) state_nxt = wfc_pkg::B_IDLE;
      default:            state_nxt = wfc_pkg::B_IDLE;
    endcase
  end

  // Datapath, memory controls and results.
  always_comb begin
    inside_nxt = inside_r;
    ovl_nxt    = ovl_r;
    halted_nxt = halted_r;
    eot_nxt    = eot_r;
    len_nxt    = len_r;
    i_nxt      = i_r;
    used_nxt   = used_r;
    e_nxt      = e_r;
    base_nxt   = base_r;
    total_nxt  = total_r;
    cnt_nxt    = cnt_r;
    od_nxt     = od_r;
    ov_nxt     = ov_r && !out_ready;
    wb_we      = 1'b0;
    wb_waddr   = WAW'(len_r);
    wb_wdata   = cmd.up_byte;
    wb_re      = 1'b0;
    wb_raddr   = WAW'(i_r);
    st_we      = 1'b0;
    st_waddr   = SAW'(base_r + BW'(i_r));
    st_re      = 1'b0;
    st_raddr   = SAW'(base_r + BW'(i_r));
    en_we      = 1'b0;
    en_waddr   = EAW'(e_r);
    en_wdata   = {len_r, cnt_inc};
    en_re      = 1'b0;
    en_raddr   = EAW'(e_r);
    case (state_r)
      wfc_pkg::B_IDLE: begin
        if (cmd_valid) begin
          eot_nxt = cmd.eot;
          // Word building on a non-separator byte.
          if (!halted_r && !cmd.sep) begin
            if (!inside_r) begin
              inside_nxt = 1'b1;
              if (total_r != 16'hFFFF) total_nxt = total_r + 16'd1;
              wb_we    = 1'b1;
              wb_waddr = '0;
              len_nxt  = LW'(1);
              ovl_nxt  = 1'b0;
            end else if (len_r < LW'(MAX_WORD_CHARS)) begin
              wb_we   = 1'b1;
              len_nxt = len_r + LW'(1);
            end else begin
              ovl_nxt = 1'b1;
            end
          end
          if (do_finish) begin
            inside_nxt = 1'b0;
            e_nxt      = '0;
            base_nxt   = '0;
          end else if (cmd.eot) begin
            e_nxt = used_r;
          end
        end
      end
      wfc_pkg::B_LEN_RD: en_re = e_r != used_r;
      wfc_pkg::B_LEN_CHK: begin
        cnt_nxt = en_rdata[15:0];
        i_nxt   = '0;
        if (en_rdata[16 +: LW] != len_r) begin
          e_nxt    = e_r + UW'(1);
          base_nxt = base_r + BW'(MAX_WORD_CHARS);
        end
      end
      wfc_pkg::B_CHR_RD: begin
        wb_re = 1'b1;
        st_re = 1'b1;
      end
      wfc_pkg::B_CHR_CHK: begin
        if (st_rdata != wb_rdata) begin
          e_nxt    = e_r + UW'(1);
          base_nxt = base_r + BW'(MAX_WORD_CHARS);
        end else if (!last_i) begin
          i_nxt = i_r + LW'(1);
        end
      end
      wfc_pkg::B_MISS: begin
        i_nxt = '0;
        // Table full: halt and report the dropped word.
        if (full && out_free) begin
          halted_nxt = 1'b1;
          ov_nxt     = 1'b1;
          od_nxt     = '{report_kind: wfc_pkg::KIND_WORD, entry_index: 4'd0,
                         count_value: 16'd0, was_new: 1'b0, truncated: ovl_r,
                         table_full: 1'b1, last_result: !eot_r};
          e_nxt      = used_r;
        end
      end
      wfc_pkg::B_CP_RD: wb_re = 1'b1;
      wfc_pkg::B_CP_WR: begin
        st_we = 1'b1;
        if (!last_i) i_nxt = i_r + LW'(1);
      end
      wfc_pkg::B_NEW: begin
        if (out_free) begin
          en_we    = 1'b1;
          en_waddr = EAW'(used_r);
          en_wdata = {len_r, 16'd1};
          used_nxt = used_r + UW'(1);
          e_nxt    = used_r + UW'(1);
          ov_nxt   = 1'b1;
          od_nxt   = '{report_kind: wfc_pkg::KIND_WORD, entry_index: 4'(used_r),
                       count_value: 16'd1, was_new: 1'b1, truncated: ovl_r,
                       table_full: halted_r, last_result: !eot_r};
        end
      end
      wfc_pkg::B_HIT: begin
        if (out_free) begin
          en_we  = 1'b1;
          ov_nxt = 1'b1;
          od_nxt = '{report_kind: wfc_pkg::KIND_WORD, entry_index: 4'(e_r),
                     count_value: cnt_inc, was_new: 1'b0, truncated: ovl_r,
                     table_full: halted_r, last_result: !eot_r};
          e_nxt  = used_r;
        end
      end
      wfc_pkg::B_REP_RD: begin
        en_re    = e_r != '0;
        en_raddr = EAW'(e_dec);
      end
      wfc_pkg::B_REP_OUT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '{report_kind: wfc_pkg::KIND_ENTRY, entry_index: 4'(e_dec),
                     count_value: en_rdata[15:0], was_new: 1'b0, truncated: 1'b0,
                     table_full: halted_r, last_result: 1'b0};
          e_nxt  = e_dec;
        end
      end
      wfc_pkg::B_TOTAL: begin
        // Final total, then back to the reset state.
        if (out_free) begin
          ov_nxt     = 1'b1;
          od_nxt     = '{report_kind: wfc_pkg::KIND_TOTAL, entry_index: 4'd0,
                         count_value: total_r, was_new: 1'b0, truncated: 1'b0,
                         table_full: halted_r, last_result: 1'b1};
          inside_nxt = 1'b0;
          len_nxt    = '0;
          ovl_nxt    = 1'b0;
          used_nxt   = '0;
          total_nxt  = '0;
          halted_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wfc_pkg::B_IDLE;
      inside_r <= 1'b0;
      ovl_r    <= 1'b0;
      halted_r <= 1'b0;
      len_r    <= '0;
      used_r   <= '0;
      total_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inside_r <= inside_nxt;
      ovl_r    <= ovl_nxt;
      halted_r <= halted_nxt;
      len_r    <= len_nxt;
      used_r   <= used_nxt;
      total_r  <= total_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eot_r  <= eot_nxt;
    i_r    <= i_nxt;
    e_r    <= e_nxt;
    base_r <= base_nxt;
    cnt_r  <= cnt_nxt;
    od_r   <= od_nxt;
  end

endmodule
`default_nettype wire

// File: sv/word_frequency_counter_unit.sv
// Word frequency counter: top level joining front end, command queue and
// back end. Depends on wfc_pkg, wfc_front, wfc_fifo, wfc_back.
//
// Usage: text bytes enter on the in_ channel (valid/ready), one request per
// byte; end_of_text marks the last byte. Results leave on the out_ channel
// (valid/ready) from a single output register.
// Throughput: plain bytes, which do not end a word, stream at one per cycle
// while the back end is idle. A word end runs the table search in the back
// end: it probes each entry's length, compares the characters of an entry
// of matching length, and on a miss copies the word in if the table has room;
// the queue keeps taking bytes meanwhile until it fills. The end-of-text
// report reads out each stored entry and then the total.
// Reset: rst_n clears the table, the counters and both channels; no
// clearing pass is needed. On a receiver stall the result holds and the back
// end waits at its next result; the queue then fills and in_ready drops.
`default_nettype none
module word_frequency_counter_unit #(
  parameter int MAX_WORD_CHARS = wfc_pkg::MAX_WORD_CHARS_DEF,
  parameter int TABLE_ENTRIES  = wfc_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire wfc_pkg::in_req_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wfc_pkg::out_req_t     out_data
);

  logic          f_valid, f_ready, q_valid, q_pop;
  wfc_pkg::cmd_t f_cmd, q_cmd;

  wfc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
  );

  wfc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(f_valid), .push_cmd(f_cmd),
    .push_ready(f_ready), .pop(q_pop), .pop_valid(q_valid), .pop_cmd(q_cmd)
  );

  wfc_back #(
    .MAX_WORD_CHARS(MAX_WORD_CHARS),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd(q_cmd),
    .cmd_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  // The total count always closes a report.
  a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.report_kind == wfc_pkg::KIND_TOTAL |-> out_data.last_result)
    else $error("total report without last_result");

  // The back end only pops when the queue holds a request.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // No result right after reset.
  a_reset_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
